// File: hdl/bthp_pkg.sv
// shared types for the branch target hysteresis predictor
package bthp_pkg;

  // outcome reported for one resolved branch
  typedef struct packed {
    logic hit;
    logic correct;
  } bthp_result_t;

endpackage

// File: hdl/bthp_ram.sv
// generic single-port-write, single-port-read ram with registered read data
module bthp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/bthp_update.sv
// entry lookup and hysteresis update for one resolved branch
module bthp_update #(
  parameter int TagW = 54,
  parameter int TgtW = 32
) (
  input  logic                    ent_valid_i,
  input  logic [TagW-1:0]         ent_tag_i,
  input  logic [TgtW-1:0]         ent_last_i,
  input  logic [TgtW-1:0]         ent_pred_i,
  input  logic                    ent_pvalid_i,
  input  logic [TagW-1:0]         tag_i,
  input  logic [TgtW-1:0]         target_i,
  output logic                    new_valid_o,
  output logic [TagW-1:0]         new_tag_o,
  output logic [TgtW-1:0]         new_last_o,
  output logic [TgtW-1:0]         new_pred_o,
  output logic                    new_pvalid_o,
  output bthp_pkg::bthp_result_t  result_o
);

  logic hit;
  logic target_matches;
  logic last_matches;

  assign hit            = ent_valid_i && (ent_tag_i == tag_i);
  assign target_matches = ent_pvalid_i && (ent_pred_i == target_i);
  assign last_matches   = ent_pvalid_i && (ent_pred_i == ent_last_i);

  always_comb begin
    new_valid_o      = 1'b1;
    new_tag_o        = tag_i;
    new_last_o       = target_i;
    new_pred_o       = ent_pred_i;
    new_pvalid_o     = ent_pvalid_i;
    result_o.hit     = hit;
    result_o.correct = hit && target_matches;
    if (!hit) begin
      // fill: actual target goes into both slots
      new_pred_o   = target_i;
      new_pvalid_o = 1'b1;
    end else if (target_i == ent_last_i) begin
      // seen twice in a row, promote to prediction
      new_pred_o   = target_i;
      new_pvalid_o = 1'b1;
    end else if (!target_matches && !last_matches) begin
      new_pred_o   = '0;
      new_pvalid_o = 1'b0;
    end
  end

endmodule

// File: hdl/branch_target_hysteresis_predictor_core.sv
// top level of the branch target hysteresis predictor
//
// one resolved conditional branch per item: its address and the id of the
// block actually taken. a direct-mapped tagged table (TABLE_ENTRIES entries,
// a power of two) is indexed by the low address bits; each entry keeps the
// last taken target and a clearable predicted target. for every item the
// block reports on done_o, past the s1 and result registers and for exactly
// one cycle, whether the table had an entry for the branch and whether its
// valid prediction matched. the receiver cannot stall, so results are simply
// presented and gone. once ready, busy_o stays low and an item is taken on
// every cycle with start_i high: one table read and one write per item, the
// read registered in the ram, with the entry written on the previous cycle
// forwarded so back-to-back items on the same entry see fresh data.
// after reset the block sweeps the table once to clear the valid bits, one
// entry per cycle, holding busy_o high until the last entry is cleared.
module branch_target_hysteresis_predictor_core #(
  parameter int TABLE_ENTRIES = 1024,
  parameter int TARGET_BITS   = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [63:0] branch_address_i,
  input  logic [31:0] taken_target_id_i,
  output logic        done_o,
  output logic        entry_hit_o,
  output logic        prediction_correct_o
);

  localparam int IdxW  = $clog2(TABLE_ENTRIES);
  localparam int TagW  = 64 - IdxW;
  // only the low TARGET_BITS of the id matter, and the id is 32 bits wide
  localparam int TgtW  = (TARGET_BITS < 32) ? TARGET_BITS : 32;
  localparam int WordW = 1 + TagW + 2 * TgtW + 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_ENTRIES - 1);

  // table clear sweep after reset
  logic            clr_active_q, clr_active_d;
  logic [IdxW-1:0] clr_idx_q, clr_idx_d;

  // item in flight between ram read and write-back
  logic            s1_valid_q;
  logic [IdxW-1:0] s1_idx_q;
  logic [TagW-1:0] s1_tag_q;
  logic [TgtW-1:0] s1_tgt_q;

  // copy of the entry written last cycle, for same-entry back-to-back items
  logic             byp_valid_q;
  logic [IdxW-1:0]  byp_idx_q;
  logic [WordW-1:0] byp_word_q;

  // result register
  logic done_q;
  bthp_pkg::bthp_result_t res_q, res_d;

  logic             accept;
  logic [WordW-1:0] rd_word;
  logic [WordW-1:0] cur_word;
  logic [WordW-1:0] new_word;
  logic             ram_we;
  logic [IdxW-1:0]  ram_waddr;
  logic [WordW-1:0] ram_wdata;

  logic            ent_valid, ent_pvalid;
  logic [TagW-1:0] ent_tag;
  logic [TgtW-1:0] ent_last, ent_pred;
  logic            new_valid, new_pvalid;
  logic [TagW-1:0] new_tag;
  logic [TgtW-1:0] new_last, new_pred;

  assign busy_o = clr_active_q;
  assign accept = start_i && !clr_active_q;

  // clear sweep control
  always_comb begin
    clr_active_d = clr_active_q;
    clr_idx_d    = clr_idx_q;
    if (clr_active_q) begin
      clr_idx_d = clr_idx_q + 1'b1;
      if (clr_idx_q == LastIdx) begin
        clr_active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_idx_q    <= '0;
      s1_valid_q   <= 1'b0;
      byp_valid_q  <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      clr_active_q <= clr_active_d;
      clr_idx_q    <= clr_idx_d;
      s1_valid_q   <= accept;
      byp_valid_q  <= s1_valid_q;
      done_q       <= s1_valid_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_idx_q <= branch_address_i[IdxW-1:0];
      s1_tag_q <= branch_address_i[63:IdxW];
      s1_tgt_q <= taken_target_id_i[TgtW-1:0];
    end
    if (s1_valid_q) begin
      byp_idx_q  <= s1_idx_q;
      byp_word_q <= new_word;
      res_q      <= res_d;
    end
  end

  // table: {valid, tag, last target, predicted target, prediction valid}
  assign ram_we    = clr_active_q || s1_valid_q;
  assign ram_waddr = clr_active_q ? clr_idx_q : s1_idx_q;
  assign ram_wdata = clr_active_q ? '0 : new_word;

  bthp_ram #(
    .Width (WordW),
    .Depth (TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (branch_address_i[IdxW-1:0]),
    .rdata_o (rd_word)
  );

  // the ram returns pre-write data when the same entry was written last cycle
  assign cur_word = (byp_valid_q && (byp_idx_q == s1_idx_q)) ? byp_word_q : rd_word;
  assign {ent_valid, ent_tag, ent_last, ent_pred, ent_pvalid} = cur_word;
  assign new_word = {new_valid, new_tag, new_last, new_pred, new_pvalid};

  bthp_update #(
    .TagW (TagW),
    .TgtW (TgtW)
  ) u_update (
    .ent_valid_i  (ent_valid),
    .ent_tag_i    (ent_tag),
    .ent_last_i   (ent_last),
    .ent_pred_i   (ent_pred),
    .ent_pvalid_i (ent_pvalid),
    .tag_i        (s1_tag_q),
    .target_i     (s1_tgt_q),
    .new_valid_o  (new_valid),
    .new_tag_o    (new_tag),
    .new_last_o   (new_last),
    .new_pred_o   (new_pred),
    .new_pvalid_o (new_pvalid),
    .result_o     (res_d)
  );

  assign done_o               = done_q;
  assign entry_hit_o          = res_q.hit;
  assign prediction_correct_o = res_q.correct;

endmodule

// File: hdl/bthp_checker.sv
// port-level checks for the branch target hysteresis predictor, bound to the top
module bthp_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic done_o,
  input logic entry_hit_o,
  input logic prediction_correct_o
);

  // every accepted item produces a result on done_o
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##2 done_o)
    else $error("accepted item produced no result");

  // no result without an earlier accepted item
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 2))
    else $error("result without accepted item");

  // a correct prediction needs a table hit
  a_correct_needs_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && prediction_correct_o) |-> entry_hit_o)
    else $error("correct prediction without hit");

  // once the clear sweep ends the block stays ready
  a_ready_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |=> !busy_o)
    else $error("busy rose after clear sweep");

  // no results while the table is being cleared
  a_quiet_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> !done_o)
    else $error("result during clear sweep");

endmodule

bind branch_target_hysteresis_predictor_core bthp_checker u_bthp_checker (.*);

// File: bench/testbench.sv
// self-checking testbench for the branch target hysteresis predictor core
`timescale 1ns / 1ps

module testbench;

  localparam int TABLE_ENTRIES = 1024;
  localparam int TARGET_BITS   = 32;
  localparam int IDX_BITS      = $clog2(TABLE_ENTRIES);
  localparam int RANDOM_ITEMS  = 1100;
  localparam int POOL_SIZE     = 12;
  // clear sweep plus every item waiting out the longest gap, several times over
  localparam int CYCLE_LIMIT   = 100000;
  localparam int DRAIN_CYCLES  = 10;
  localparam int REPORT_LIMIT  = 10;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [63:0] branch_address_i;
  logic [31:0] taken_target_id_i;
  logic        done_o;
  logic        entry_hit_o;
  logic        prediction_correct_o;

  branch_target_hysteresis_predictor_core #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .TARGET_BITS  (TARGET_BITS)
  ) u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start_i             (start_i),
    .busy_o              (busy_o),
    .branch_address_i    (branch_address_i),
    .taken_target_id_i   (taken_target_id_i),
    .done_o              (done_o),
    .entry_hit_o         (entry_hit_o),
    .prediction_correct_o(prediction_correct_o)
  );

  always #5 clk_i = ~clk_i;

  // one row of the directed part; typed rows carry a hand-written outcome
  typedef struct {
    logic [63:0]            addr;
    logic [31:0]            target;
    bit                     typed;
    bthp_pkg::bthp_result_t outcome;
  } branch_row_t;

  // shadow copy of the target table
  logic                  shadow_valid  [TABLE_ENTRIES];
  logic [63-IDX_BITS:0]  shadow_tag    [TABLE_ENTRIES];
  logic [31:0]           shadow_last   [TABLE_ENTRIES];
  logic [31:0]           shadow_pred   [TABLE_ENTRIES];
  logic                  shadow_pvalid [TABLE_ENTRIES];

  bthp_pkg::bthp_result_t expected_outcomes[$];
  branch_row_t            directed_rows[$];

  // side info for the item on the ports, driven along with start_i
  bit                     item_typed;
  bthp_pkg::bthp_result_t item_outcome;
  bthp_pkg::bthp_result_t predicted;
  bthp_pkg::bthp_result_t oldest;

  int error_count;
  int cycle_count;

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= REPORT_LIMIT) $display("error: %s", msg);
  endtask

  // resolve one branch against the shadow table, return the outcome the block should report
  function automatic bthp_pkg::bthp_result_t resolve_branch(input logic [63:0] addr,
                                                            input logic [31:0] target);
    logic [IDX_BITS-1:0]    slot;
    logic [63-IDX_BITS:0]   tag;
    bthp_pkg::bthp_result_t res;
    slot        = addr[IDX_BITS-1:0];
    tag         = addr[63:IDX_BITS];
    res.hit     = shadow_valid[slot] && (shadow_tag[slot] == tag);
    res.correct = 1'b0;
    if (!res.hit) begin
      // fill on a cold entry or a tag conflict: both slots take the target
      shadow_valid[slot]  = 1'b1;
      shadow_tag[slot]    = tag;
      shadow_last[slot]   = target;
      shadow_pred[slot]   = target;
      shadow_pvalid[slot] = 1'b1;
    end else begin
      res.correct = shadow_pvalid[slot] && (shadow_pred[slot] == target);
      if (target == shadow_last[slot]) begin
        // seen twice in a row: promote to prediction
        shadow_pred[slot]   = target;
        shadow_pvalid[slot] = 1'b1;
      end else begin
        // new target, and last target also missed the prediction: drop it
        if (!res.correct && !(shadow_pvalid[slot] && shadow_pred[slot] == shadow_last[slot]))
        begin
          shadow_pvalid[slot] = 1'b0;
          shadow_pred[slot]   = '0;
        end
        shadow_last[slot] = target;
      end
    end
    return res;
  endfunction

  task automatic add_row(input logic [63:0] addr, input logic [31:0] target,
                         input bit typed, input logic hit, input logic correct);
    branch_row_t row;
    row.addr            = addr;
    row.target          = target;
    row.typed           = typed;
    row.outcome.hit     = hit;
    row.outcome.correct = correct;
    directed_rows.push_back(row);
  endtask

  // present one item after an optional idle gap and hold it until the block takes it
  task automatic send_branch(input logic [63:0] addr, input logic [31:0] target,
                             input bit typed, input bthp_pkg::bthp_result_t outcome,
                             input int gap);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i           <= 1'b1;
    branch_address_i  <= addr;
    taken_target_id_i <= target;
    item_typed        <= typed;
    item_outcome      <= outcome;
    do @(posedge clk_i); while (busy_o);
  endtask

  // monitor: check results first, then log the item taken at this edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        if (expected_outcomes.size() == 0) begin
          flag_error($sformatf("result hit=%0b correct=%0b with no item waiting",
                               entry_hit_o, prediction_correct_o));
        end else begin
          oldest = expected_outcomes.pop_front();
          if (entry_hit_o !== oldest.hit || prediction_correct_o !== oldest.correct) begin
            flag_error($sformatf("expected hit=%0b correct=%0b, got hit=%0b correct=%0b",
                                 oldest.hit, oldest.correct,
                                 entry_hit_o, prediction_correct_o));
          end
        end
      end
      if (start_i && !busy_o) begin
        predicted = resolve_branch(branch_address_i, taken_target_id_i);
        if (item_typed) expected_outcomes.push_back(item_outcome);
        else expected_outcomes.push_back(predicted);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    logic [63:0]            pool_addr    [POOL_SIZE];
    logic [31:0]            pool_targets [POOL_SIZE][3];
    logic [31:0]            pool_recent  [POOL_SIZE];
    logic [63:0]            tag_choices  [3];
    logic [63:0]            addr;
    logic [31:0]            target;
    bthp_pkg::bthp_result_t none;
    bit                     no_idle;
    int                     pick;
    int                     gap;
    int                     waited;

    clk_i             = 1'b0;
    rst_ni            = 1'b0;
    start_i           = 1'b0;
    branch_address_i  = '0;
    taken_target_id_i = '0;
    item_typed        = 1'b0;
    item_outcome      = '0;
    none              = '0;
    error_count       = 0;
    cycle_count       = 0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      shadow_valid[i]  = 1'b0;
      shadow_tag[i]    = '0;
      shadow_last[i]   = '0;
      shadow_pred[i]   = '0;
      shadow_pvalid[i] = 1'b0;
    end

    // cold entry, then a repeat of the same branch and target
    add_row(64'h0, 32'h0, 1, 1'b0, 1'b0);
    add_row(64'h0, 32'h0, 1, 1'b1, 1'b1);
    // all-ones address and target
    add_row(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1, 1'b0, 1'b0);
    add_row(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1, 1'b1, 1'b1);
    // new target keeps the prediction while the last target still matched it
    add_row(64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 1, 1'b1, 1'b0);
    add_row(64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 0, 1'b0, 1'b0);
    add_row(64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 0, 1'b0, 1'b0);
    // tag conflict on the top index evicts, and the old branch misses again
    add_row(64'h0000_0000_0000_03FF, 32'h5555_5555, 1, 1'b0, 1'b0);
    add_row(64'hFFFF_FFFF_FFFF_FFFF, 32'hAAAA_AAAA, 1, 1'b0, 1'b0);
    add_row(64'h0000_0000_0000_03FF, 32'h5555_5555, 1, 1'b0, 1'b0);
    // top tag bit alone conflicts with address zero
    add_row(64'h8000_0000_0000_0000, 32'h8000_0000, 1, 1'b0, 1'b0);
    add_row(64'h0, 32'h0, 1, 1'b0, 1'b0);
    // hysteresis: two new targets in a row clear the prediction
    add_row(64'h0000_1234_5678_9005, 32'h0000_00A1, 1, 1'b0, 1'b0);
    add_row(64'h0000_1234_5678_9005, 32'h0000_00B2, 1, 1'b1, 1'b0);
    add_row(64'h0000_1234_5678_9005, 32'h0000_00C3, 0, 1'b0, 1'b0);
    // cleared prediction stays cleared on yet another target
    add_row(64'h0000_1234_5678_9005, 32'h0000_00D4, 0, 1'b0, 1'b0);
    // repeat restores it, and the next repeat is predicted
    add_row(64'h0000_1234_5678_9005, 32'h0000_00D4, 0, 1'b0, 1'b0);
    add_row(64'h0000_1234_5678_9005, 32'h0000_00D4, 0, 1'b0, 1'b0);
    // target swinging back to the prediction after one excursion
    add_row(64'h0000_1234_5678_9005, 32'h0000_00E5, 0, 1'b0, 1'b0);
    add_row(64'h0000_1234_5678_9005, 32'h0000_00D4, 0, 1'b0, 1'b0);
    // neighbors on adjacent indices stay apart
    add_row(64'h0000_1234_5678_9004, 32'h0000_00D4, 1, 1'b0, 1'b0);
    add_row(64'h0000_1234_5678_9006, 32'h0000_00D4, 1, 1'b0, 1'b0);
    add_row(64'h0000_1234_5678_9005, 32'h0000_00D4, 0, 1'b0, 1'b0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // back to back, so the same-entry forwarding path is exercised
    foreach (directed_rows[i]) begin
      send_branch(directed_rows[i].addr, directed_rows[i].target,
                  directed_rows[i].typed, directed_rows[i].outcome, 0);
    end

    no_idle = 1'b0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // fresh working set of branches now and then, sharing a few indices and tags
      if (n % 200 == 0) begin
        for (int t = 0; t < 3; t++) tag_choices[t] = {$urandom(), $urandom()};
        for (int p = 0; p < POOL_SIZE; p++) begin
          pool_addr[p] = tag_choices[$urandom_range(0, 2)];
          pool_addr[p][IDX_BITS-1:0] = $urandom_range(0, 1)
                                       ? IDX_BITS'($urandom_range(0, 5))
                                       : IDX_BITS'($urandom_range(1018, 1023));
          for (int k = 0; k < 3; k++) pool_targets[p][k] = $urandom();
          pool_recent[p] = pool_targets[p][0];
        end
      end
      if (n % 50 == 0) no_idle = ($urandom_range(0, 2) == 0);

      if ($urandom_range(0, 9) < 2) begin
        // noise: any address, any target
        addr   = {$urandom(), $urandom()};
        target = $urandom();
      end else begin
        pick = $urandom_range(0, POOL_SIZE - 1);
        addr = pool_addr[pick];
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: target = pool_recent[pick];
          9:                target = $urandom();
          default:          target = pool_targets[pick][$urandom_range(0, 2)];
        endcase
        pool_recent[pick] = target;
      end
      gap = no_idle ? 0 : $urandom_range(0, 6);
      send_branch(addr, target, 0, none, gap);
    end
    start_i <= 1'b0;

    waited = 0;
    while (expected_outcomes.size() != 0 && waited < 1000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_outcomes.size() != 0) begin
      flag_error($sformatf("%0d results never arrived", expected_outcomes.size()));
    end

    if (error_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// File: branch_target_hysteresis_predictor_core.f
hdl/bthp_pkg.sv
hdl/bthp_ram.sv
hdl/bthp_update.sv
hdl/branch_target_hysteresis_predictor_core.sv
hdl/bthp_checker.sv
bench/testbench.sv
